[hw/rtl/window_jitter_estimator_unit_macros.svh]
`ifndef WINDOW_JITTER_ESTIMATOR_UNIT_MACROS_SVH
`define WINDOW_JITTER_ESTIMATOR_UNIT_MACROS_SVH

// same-cycle implication
`define JWE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define JWE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/jwe_pkg.sv]
package jwe_pkg;

  localparam int unsigned DEPTH    = 64;
  localparam int unsigned PTR_W    = $clog2(DEPTH);
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned TS_W     = 48;
  localparam int unsigned EST_W    = 32;
  localparam int unsigned ACC_W    = EST_W + FRAC_W;
  localparam int unsigned WS_W     = 7;
  localparam int unsigned WS_RESET = 10;

  typedef struct packed {
    logic [TS_W-1:0] media_timestamp;
    logic [TS_W-1:0] arrival_time;
  } jwe_in_t;

  typedef struct packed {
    logic [EST_W-1:0] jitter_estimate;
    logic [EST_W:0]   buffer_delay;
  } jwe_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } jwe_state_t;

endpackage

[hw/rtl/window_jitter_estimator_unit.sv]
// Windowed interarrival jitter estimator.
// Input channel (in_valid/in_ready/in_data): one word per sample, carrying the
// media timestamp and the local arrival time. Result channel
// (out_valid/out_ready/out_data): one word per input word, carrying the jitter
// estimate and twice that figure as a buffering delay.
// cfg_we/cfg_wdata set the window size (1..64; 0 acts as 1, above 64 as 64).
// Write it only while no word is in flight.
// One word is processed at a time. With n pairs held after the push, the walk
// reads the pair memory once per pair, one read per cycle, through a
// three-stage deviation/average pipe; the estimate is then loaded into the
// output register and the next word is accepted once it is loaded. While
// fewer than two pairs are held no walk runs and the held estimate is loaded
// directly.
// The result sits in an output register; a new word is accepted while it
// waits, but the next result stalls until the receiver takes the current one.
// Reset empties the window, clears the estimate to zero and sets the window
// size to 10. Memory contents are not cleared and need no clearing pass.
`include "window_jitter_estimator_unit_macros.svh"

module window_jitter_estimator_unit
  import jwe_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  jwe_in_t         in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output jwe_out_t        out_data,
  input  logic            cfg_we,
  input  logic [WS_W-1:0] cfg_wdata
);

  jwe_state_t       state_r, state_nxt;
  logic [WS_W-1:0]  ws_r;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc, win;
  logic [EST_W-1:0] est_r;
  logic [PTR_W-1:0] iss_ptr_r;
  logic [CNT_W-1:0] iss_left_r, upd_left_r;
  logic             iss_first_r, rd_vld_r, rd_first_r;
  logic [ACC_W-1:0] acc_r, acc_upd;
  logic [ACC_W+3:0] acc_wide;
  logic             out_valid_r;
  jwe_out_t         out_data_r;
  jwe_in_t          mem [DEPTH];
  jwe_in_t          rd_data_r;
  logic [CNT_W:0]   start_ext;
  logic [PTR_W-1:0] start;
  logic             accept, rd_en, out_load, last_upd;
  logic             dev_vld;
  logic [EST_W-1:0] dev;

  assign accept = in_valid && in_ready;

  // window bookkeeping for the word being pushed
  always_comb begin
    if (ws_r == '0) begin
      win = CNT_W'(1);
    end else if (ws_r > WS_W'(DEPTH)) begin
      win = CNT_W'(DEPTH);
    end else begin
      win = CNT_W'(ws_r);
    end
    cnt_inc  = cnt_r + 1'b1;
    cnt_nxt  = (cnt_inc > win) ? win : cnt_inc;
    head_nxt = (head_r == PTR_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
    if ({1'b0, head_nxt} >= cnt_nxt) begin
      start_ext = {1'b0, CNT_W'(head_nxt)} - {1'b0, cnt_nxt};
    end else begin
      start_ext = {1'b0, CNT_W'(head_nxt)} + (CNT_W + 1)'(DEPTH) - {1'b0, cnt_nxt};
    end
    start = start_ext[PTR_W-1:0];
  end

  // acc = (15*acc + dev*2^FRAC_W) / 16
  assign acc_wide = ({acc_r, 4'b0} - {4'b0, acc_r}) + {4'b0, dev, {FRAC_W{1'b0}}};
  assign acc_upd  = acc_wide[ACC_W+3:4];
  assign last_upd = dev_vld && (upd_left_r == CNT_W'(1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (cnt_nxt >= CNT_W'(2)) ? ST_WALK : ST_DONE;
        end
      end
      ST_WALK: begin
        if (last_upd) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_WALK: rd_en = (iss_left_r != '0);
      ST_DONE: out_load = !out_valid_r || out_ready;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // pair memory
  always_ff @(posedge clk) begin
    if (accept) begin
      mem[head_r] <= in_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[iss_ptr_r];
    end
  end

  jwe_dev u_dev (
    .clk        (clk),
    .rst_n      (rst_n),
    .word_vld   (rd_vld_r),
    .word_first (rd_first_r),
    .word       (rd_data_r),
    .dev_vld    (dev_vld),
    .dev        (dev)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      acc_r <= '0;
    end else if (dev_vld) begin
      acc_r <= acc_upd;
    end
    if (out_load) begin
      out_data_r.jitter_estimate <= est_r;
      out_data_r.buffer_delay    <= {est_r, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ws_r        <= WS_W'(WS_RESET);
      head_r      <= '0;
      cnt_r       <= '0;
      est_r       <= '0;
      iss_ptr_r   <= '0;
      iss_left_r  <= '0;
      upd_left_r  <= '0;
      iss_first_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      rd_first_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_vld_r   <= rd_en;
      rd_first_r <= iss_first_r;
      if (cfg_we) begin
        ws_r <= cfg_wdata;
      end
      if (accept) begin
        head_r      <= head_nxt;
        cnt_r       <= cnt_nxt;
        iss_ptr_r   <= start;
        iss_left_r  <= cnt_nxt;
        upd_left_r  <= cnt_nxt - 1'b1;
        iss_first_r <= 1'b1;
      end else if (rd_en) begin
        iss_ptr_r   <= (iss_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : iss_ptr_r + 1'b1;
        iss_left_r  <= iss_left_r - 1'b1;
        iss_first_r <= 1'b0;
      end
      if (dev_vld) begin
        upd_left_r <= upd_left_r - 1'b1;
      end
      if (last_upd) begin
        est_r <= acc_upd[ACC_W-1:FRAC_W];
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `JWE_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(DEPTH), "pair count beyond depth")
  `JWE_ASSERT_IMP(a_dev_in_walk, dev_vld, state_r == ST_WALK, "deviation outside walk")
  `JWE_ASSERT_NXT(a_walk_start, accept && (cnt_nxt >= CNT_W'(2)), state_r == ST_WALK,
                  "walk not started")
  `JWE_ASSERT_IMP(a_done_drained, state_r == ST_DONE && cnt_r >= CNT_W'(2),
                  iss_left_r == '0 && !rd_vld_r, "result before walk drained")

endmodule

[hw/rtl/jwe_dev.sv]
// Deviation of adjacent stored words: |arrival delta - stamp delta|, saturated.
module jwe_dev
  import jwe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             word_vld,
  input  logic             word_first,
  input  jwe_in_t          word,
  output logic             dev_vld,
  output logic [EST_W-1:0] dev
);

  jwe_in_t          prev_r;
  logic [TS_W:0]    ds_r, da_r, ds_nxt, da_nxt;
  logic             dlt_vld_r;
  logic [EST_W-1:0] dev_r, dev_nxt;
  logic             dev_vld_r;
  logic [TS_W+1:0]  diff, mag;

  assign ds_nxt = {1'b0, word.media_timestamp} - {1'b0, prev_r.media_timestamp};
  assign da_nxt = {1'b0, word.arrival_time} - {1'b0, prev_r.arrival_time};

  assign diff    = {da_r[TS_W], da_r} - {ds_r[TS_W], ds_r};
  assign mag     = diff[TS_W+1] ? (~diff + 1'b1) : diff;
  assign dev_nxt = (|mag[TS_W+1:EST_W]) ? {EST_W{1'b1}} : mag[EST_W-1:0];

  always_ff @(posedge clk) begin
    if (word_vld) begin
      prev_r <= word;
      ds_r   <= ds_nxt;
      da_r   <= da_nxt;
    end
    if (dlt_vld_r) begin
      dev_r <= dev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dlt_vld_r <= 1'b0;
      dev_vld_r <= 1'b0;
    end else begin
      dlt_vld_r <= word_vld && !word_first;
      dev_vld_r <= dlt_vld_r;
    end
  end

  assign dev_vld = dev_vld_r;
  assign dev     = dev_r;

endmodule

[test/tb_window_jitter_estimator_unit.sv]
`timescale 1ns / 100ps

module tb_window_jitter_estimator_unit;
  import jwe_pkg::*;

  typedef struct {
    bit              set_ws;
    logic [WS_W-1:0] ws;
    logic [TS_W-1:0] ts;
    logic [TS_W-1:0] arr;
    bit              known;
    logic [EST_W-1:0] est;
  } plan_row_t;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  jwe_in_t         in_data;
  logic            out_valid;
  logic            out_ready;
  jwe_out_t        out_data;
  logic            cfg_we;
  logic [WS_W-1:0] cfg_wdata;

  // software copy of the window
  logic [TS_W-1:0]  pair_stamp [DEPTH];
  logic [TS_W-1:0]  pair_arrival [DEPTH];
  logic [PTR_W-1:0] pair_head;
  int unsigned      pairs_held;
  logic [EST_W-1:0] jitter_held;
  logic [WS_W-1:0]  window_reg;

  plan_row_t plan [$];
  jwe_out_t est_due [$];
  int unsigned errs;
  bit want_hold;

  window_jitter_estimator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic logic [TS_W-1:0] rand48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[TS_W-1:0];
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(15, 70);
  endfunction

  function automatic void add_row(input bit set_ws, input logic [WS_W-1:0] ws,
                                  input logic [TS_W-1:0] ts, input logic [TS_W-1:0] arr,
                                  input bit known, input logic [EST_W-1:0] est);
    plan_row_t row;
    row = '{set_ws, ws, ts, arr, known, est};
    plan = {plan, row};
  endfunction

  // push the pair, then refold the whole window oldest to newest
  function automatic jwe_out_t fold_sample(input jwe_in_t w);
    int unsigned lim, first, i, a, b;
    longint ts_d, arr_d, diff;
    logic [63:0] mag, acc;
    jwe_out_t r;
    if (window_reg == 0) lim = 1;
    else if (window_reg > DEPTH) lim = DEPTH;
    else lim = 32'(window_reg);
    pair_stamp[pair_head] = w.media_timestamp;
    pair_arrival[pair_head] = w.arrival_time;
    pair_head = pair_head + 1'b1;
    pairs_held = (pairs_held + 1 > lim) ? lim : pairs_held + 1;
    if (pairs_held >= 2) begin
      acc = '0;
      first = (pair_head + DEPTH - pairs_held) % DEPTH;
      for (i = 1; i < pairs_held; i++) begin
        a = (first + i - 1) % DEPTH;
        b = (first + i) % DEPTH;
        ts_d = $signed({16'd0, pair_stamp[b]}) - $signed({16'd0, pair_stamp[a]});
        arr_d = $signed({16'd0, pair_arrival[b]}) - $signed({16'd0, pair_arrival[a]});
        diff = arr_d - ts_d;
        mag = (diff < 0) ? 64'(-diff) : 64'(diff);
        if (mag > 64'hFFFF_FFFF) mag = 64'hFFFF_FFFF;
        acc = (acc * 15 + (mag << FRAC_W)) >> 4;
      end
      jitter_held = acc[FRAC_W +: EST_W];
    end
    r.jitter_estimate = jitter_held;
    r.buffer_delay = {jitter_held, 1'b0};
    return r;
  endfunction

  task automatic offer_sample(input jwe_in_t w, input bit known,
                              input logic [EST_W-1:0] est);
    jwe_out_t want;
    in_data <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = fold_sample(w);
    if (known) begin
      want.jitter_estimate = est;
      want.buffer_delay = {est, 1'b0};
    end
    est_due = {est_due, want};
    @(negedge clk);
  endtask

  task automatic hold_input(input int unsigned n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (est_due.size() != 0);
  endtask

  task automatic write_window(input logic [WS_W-1:0] ws);
    settle();
    cfg_wdata <= ws;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    window_reg = ws;
  endtask

  always @(posedge clk) begin
    jwe_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (est_due.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, out_data);
        errs++;
      end else begin
        want = est_due[0];
        est_due.delete(0);
        if (out_data.jitter_estimate !== want.jitter_estimate) begin
          $display("%0t: jitter_estimate expected %h actual %h", $time,
                   want.jitter_estimate, out_data.jitter_estimate);
          errs++;
        end
        if (out_data.buffer_delay !== want.buffer_delay) begin
          $display("%0t: buffer_delay expected %h actual %h", $time,
                   want.buffer_delay, out_data.buffer_delay);
          errs++;
        end
      end
    end
  end

  // receiver: random stalls, calm stretches, one long hold-off
  initial begin
    int unsigned stall_left, cyc;
    bit calm, hold_taken;
    stall_left = 0;
    cyc = 0;
    calm = 1'b0;
    hold_taken = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 200 == 0) calm = ($urandom_range(0, 2) == 0);
      if (want_hold && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!calm) stall_left = idle_len();
      end
    end
  end

  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    jwe_in_t w;
    logic [TS_W-1:0] ts_now, arr_off;
    logic [WS_W-1:0] ws;
    logic [31:0] step, jit;
    int unsigned p, k, r, jmax;
    bit burst;

    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    errs = 0;
    want_hold = 1'b0;
    pair_head = '0;
    pairs_held = 0;
    jitter_held = '0;
    window_reg = WS_W'(WS_RESET);

    add_row(1'b0, 7'd0, 48'd0, 48'd0, 1'b1, 32'd0);
    add_row(1'b0, 7'd0, 48'd1000, 48'd1000, 1'b1, 32'd0);
    add_row(1'b0, 7'd0, 48'd2000, 48'd2160, 1'b1, 32'd10);
    // backward stamp, saturating deviation
    add_row(1'b0, 7'd0, 48'd0, 48'hFFFF_FFFF_FFFF, 1'b0, 32'd0);
    add_row(1'b0, 7'd0, 48'hFFFF_FFFF_FFFF, 48'd0, 1'b0, 32'd0);
    add_row(1'b0, 7'd0, 48'd16, 48'd16, 1'b0, 32'd0);
    add_row(1'b0, 7'd0, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 1'b0, 32'd0);
    add_row(1'b0, 7'd0, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 1'b0, 32'd0);
    add_row(1'b0, 7'd0, 48'd10000, 48'd10000, 1'b0, 32'd0);
    add_row(1'b0, 7'd0, 48'd20000, 48'd20123, 1'b0, 32'd0);
    add_row(1'b0, 7'd0, 48'd30000, 48'd29990, 1'b0, 32'd0);
    // shrink below the pairs held
    add_row(1'b1, 7'd2, 48'd40000, 48'd40050, 1'b0, 32'd0);
    add_row(1'b1, 7'd1, 48'd50000, 48'd59999, 1'b0, 32'd0);
    add_row(1'b1, 7'd0, 48'd60000, 48'd60000, 1'b0, 32'd0);
    add_row(1'b1, 7'd64, 48'd70000, 48'd70700, 1'b0, 32'd0);
    add_row(1'b0, 7'd0, 48'd80000, 48'd80007, 1'b0, 32'd0);
    add_row(1'b1, 7'd127, 48'd90000, 48'd90300, 1'b0, 32'd0);
    add_row(1'b0, 7'd0, 48'd100000, 48'd99000, 1'b0, 32'd0);
    add_row(1'b1, 7'd65, 48'd110000, 48'd110001, 1'b0, 32'd0);
    add_row(1'b1, 7'd3, 48'd120000, 48'd120500, 1'b0, 32'd0);
    add_row(1'b0, 7'd0, 48'd130000, 48'd130500, 1'b0, 32'd0);

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].set_ws) write_window(plan[i].ws);
      w.media_timestamp = plan[i].ts;
      w.arrival_time = plan[i].arr;
      offer_sample(w, plan[i].known, plan[i].est);
      hold_input(idle_len());
    end

    for (p = 0; p < 9; p++) begin
      case (p)
        0: ws = 7'd2;
        1: ws = 7'd3;
        2: ws = 7'd64;
        3: ws = 7'd0;
        4: ws = 7'd127;
        5: ws = 7'd17;
        6: ws = 7'd1;
        7: ws = 7'd65;
        default: ws = WS_W'($urandom_range(2, 64));
      endcase
      write_window(ws);
      burst = (p % 3 == 2);
      ts_now = (p == 5) ? 48'hFFFF_FFFF_0000 : rand48();
      arr_off = rand48();
      case ($urandom_range(0, 3))
        0: jmax = 0;
        1: jmax = 40;
        2: jmax = 3000;
        default: jmax = 2_000_000;
      endcase
      for (k = 0; k < 110; k++) begin
        if (p == 2 && k == 40) want_hold = 1'b1;
        if (p == 4 && k == 50) settle();
        r = $urandom_range(0, 99);
        step = $urandom_range(1, 40000);
        ts_now = ts_now + {16'd0, step};
        jit = $urandom_range(0, jmax);
        if (r < 75) begin
          w.media_timestamp = ts_now;
          w.arrival_time = ts_now + arr_off + {16'd0, jit};
        end else if (r < 88) begin
          // late or reordered arrival
          jit = $urandom_range(0, 100000);
          w.media_timestamp = ts_now;
          w.arrival_time = ts_now + arr_off - {16'd0, jit};
        end else begin
          w.media_timestamp = rand48();
          w.arrival_time = rand48();
        end
        offer_sample(w, 1'b0, '0);
        if (!burst) hold_input(idle_len());
      end
    end

    settle();
    repeat (100) @(negedge clk);
    if (errs == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
